/* hw/rtl/bmfs_pkg.sv */
// ----------------------------------------------------------------------------
// bmfs_pkg
// Shared types and constants of the bandwidth max filter sampler.
// ----------------------------------------------------------------------------
package bmfs_pkg;

    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int ROUND_W = 32;
    localparam int WIN_W   = 8;
    localparam int SIZE_W  = 16;
    localparam int CMD_W   = 2;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 8'd10;
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

    localparam int MUL_SPLIT = TIME_W / 2;
    localparam int MUL_K_W   = 20;
    localparam logic [MUL_K_W-1:0] MUL_K = 20'd1000000;
    localparam int PROD_W    = MUL_SPLIT + MUL_K_W;
    localparam int NUM_W     = TIME_W + MUL_K_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = RATE_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEADER      = 2'd0,
        CMD_PACKET      = 2'd1,
        CMD_APP_LIMITED = 2'd2
    } cmd_t;

    typedef struct packed {
        logic               sample;
        logic               app;
        logic               limited;
        logic [TIME_W-1:0]  send_bytes;
        logic [TIME_W-1:0]  send_us;
        logic [TIME_W-1:0]  ack_bytes;
        logic [TIME_W-1:0]  ack_us;
        logic [ROUND_W-1:0] round;
    } entry_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_MLO,
        D_MHI,
        D_PREP,
        D_RUN
    } div_phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WAIT,
        B_UPD,
        B_DONE
    } back_state_t;

endpackage

/* hw/rtl/bmfs_front.sv */
// ----------------------------------------------------------------------------
// bmfs_front
// Classifies input items, keeps the ack-event and app-limited state and
// forms the byte and interval operands of each sample.
// ----------------------------------------------------------------------------
module bmfs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [bmfs_pkg::CMD_W-1:0]     command,
    input  logic [bmfs_pkg::TIME_W-1:0]    now_time,
    input  logic [bmfs_pkg::TIME_W-1:0]    adjusted_time,
    input  logic [bmfs_pkg::TIME_W-1:0]    mark_time,
    input  logic [bmfs_pkg::TIME_W-1:0]    byte_total,
    input  logic [bmfs_pkg::TIME_W-1:0]    byte_count,
    input  logic [bmfs_pkg::TIME_W-1:0]    prior_ack_time,
    input  logic [bmfs_pkg::TIME_W-1:0]    prior_total_acked,
    input  logic [bmfs_pkg::ROUND_W-1:0]   round_count,
    input  logic                           has_prior,
    input  logic                           sent_app_limited,
    input  logic [bmfs_pkg::SIZE_W-1:0]    packet_size,
    output bmfs_pkg::entry_t               entry
);

    logic [bmfs_pkg::TIME_W-1:0]  ack_time_reg, adj_time_reg, total_acked_reg, acked_bytes_reg;
    logic [bmfs_pkg::TIME_W-1:0]  exit_time_reg;
    logic [bmfs_pkg::ROUND_W-1:0] round_reg;
    logic                         limited_reg;
    logic                         limited_next;
    logic                         is_header;
    logic                         is_mark;

    assign is_header = (command == bmfs_pkg::CMD_HEADER);
    assign is_mark   = (command == bmfs_pkg::CMD_APP_LIMITED);

    always_comb
    begin
        limited_next = limited_reg;
        if (is_header && limited_reg && (exit_time_reg < mark_time))
        begin
            limited_next = 1'b0;
        end
        else if (is_mark)
        begin
            limited_next = 1'b1;
        end
    end

    always_comb
    begin
        entry            = '0;
        entry.sample     = (command == bmfs_pkg::CMD_PACKET) && (packet_size != '0);
        entry.app        = sent_app_limited;
        entry.limited    = limited_next;
        entry.round      = round_reg;
        if (has_prior)
        begin
            entry.send_bytes = (byte_total > byte_count) ? byte_total - byte_count : '0;
            entry.send_us    = (now_time > mark_time) ? now_time - mark_time : '0;
            entry.ack_bytes  = (total_acked_reg > prior_total_acked) ?
                               total_acked_reg - prior_total_acked : '0;
            if (adj_time_reg > adjusted_time)
            begin
                entry.ack_us = adj_time_reg - adjusted_time;
            end
            else
            begin
                entry.ack_us = (ack_time_reg > prior_ack_time) ?
                               ack_time_reg - prior_ack_time : '0;
            end
        end
        else if (ack_time_reg > now_time)
        begin
            entry.send_bytes = acked_bytes_reg;
            entry.send_us    = ack_time_reg - now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_time_reg    <= '0;
            adj_time_reg    <= '0;
            total_acked_reg <= '0;
            acked_bytes_reg <= '0;
            exit_time_reg   <= '0;
            round_reg       <= '0;
            limited_reg     <= 1'b0;
        end
        else if (push)
        begin
            limited_reg <= limited_next;
            if (is_header)
            begin
                ack_time_reg    <= now_time;
                adj_time_reg    <= adjusted_time;
                total_acked_reg <= byte_total;
                acked_bytes_reg <= byte_count;
                round_reg       <= round_count;
            end
            if (is_mark)
            begin
                exit_time_reg <= now_time;
            end
        end
    end

endmodule

/* hw/rtl/bmfs_fifo.sv */
// ----------------------------------------------------------------------------
// bmfs_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module bmfs_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmfs_pkg::entry_t wr_entry,
    input  logic             pop,
    output bmfs_pkg::entry_t rd_entry,
    output logic             full,
    output logic             empty
);

    bmfs_pkg::entry_t                    slot_reg [bmfs_pkg::FIFO_DEPTH];
    logic [bmfs_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [bmfs_pkg::FIFO_CNT_W-1:0]     count_reg;

    assign full     = (count_reg == bmfs_pkg::FIFO_CNT_W'(bmfs_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/bmfs_div.sv */
// ----------------------------------------------------------------------------
// bmfs_div
// Rate unit: bytes times one million over microseconds, saturated, by two
// partial products and a radix-4 restoring divider.
// ----------------------------------------------------------------------------
module bmfs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bmfs_pkg::TIME_W-1:0]   bytes,
    input  logic [bmfs_pkg::TIME_W-1:0]   us,
    output logic                          done,
    output logic [bmfs_pkg::RATE_W-1:0]   rate
);

    localparam int SPL = bmfs_pkg::MUL_SPLIT;
    localparam int TW  = bmfs_pkg::TIME_W;
    localparam int RW  = bmfs_pkg::RATE_W;
    localparam int NW  = bmfs_pkg::NUM_W;
    localparam int PW  = bmfs_pkg::PROD_W;
    localparam int KW  = bmfs_pkg::MUL_K_W;

    bmfs_pkg::div_phase_t              phase_reg, phase_next;
    logic [TW-1:0]                     bytes_reg, us_reg;
    logic [PW-1:0]                     plo_reg, phi_reg;
    logic [TW-1:0]                     rem_reg, rem_next;
    logic [RW-1:0]                     sh_reg, sh_next;
    logic [bmfs_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                              sat_reg, zero_reg;
    logic [NW-1:0]                     num;
    logic [TW:0]                       trial;
    logic                              qbit;
    logic                              last;

    assign last = (cnt_reg == bmfs_pkg::DIV_CNT_W'(bmfs_pkg::DIV_STEPS - 1));
    assign num  = {phi_reg, {SPL{1'b0}}} + {{SPL{1'b0}}, plo_reg};

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            bmfs_pkg::D_IDLE: if (start) phase_next = bmfs_pkg::D_MLO;
            bmfs_pkg::D_MLO:  phase_next = bmfs_pkg::D_MHI;
            bmfs_pkg::D_MHI:  phase_next = bmfs_pkg::D_PREP;
            bmfs_pkg::D_PREP: phase_next = bmfs_pkg::D_RUN;
            bmfs_pkg::D_RUN:  if (last) phase_next = bmfs_pkg::D_IDLE;
            default:          phase_next = bmfs_pkg::D_IDLE;
        endcase
    end

    always_comb
    begin
        done = (phase_reg == bmfs_pkg::D_RUN) && last;
        rate = zero_reg ? '0 : (sat_reg ? bmfs_pkg::RATE_MAX : sh_reg);
    end

    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int i = 0; i < bmfs_pkg::DIV_BITS; i++)
        begin
            trial = {rem_next, sh_next[RW-1]};
            qbit  = (trial >= {1'b0, us_reg});
            if (qbit)
            begin
                trial = trial - {1'b0, us_reg};
            end
            rem_next = trial[TW-1:0];
            sh_next  = {sh_next[RW-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bmfs_pkg::D_IDLE;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == bmfs_pkg::D_PREP)
            begin
                cnt_reg  <= '0;
                sat_reg  <= ({{(TW-(NW-RW)){1'b0}}, num[NW-1:RW]} >= us_reg);
                zero_reg <= (us_reg == '0);
            end
            else if (phase_reg == bmfs_pkg::D_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            bmfs_pkg::D_IDLE:
            begin
                if (start)
                begin
                    bytes_reg <= bytes;
                    us_reg    <= us;
                end
            end
            bmfs_pkg::D_MLO:
                plo_reg <= {{KW{1'b0}}, bytes_reg[SPL-1:0]} * {{SPL{1'b0}}, bmfs_pkg::MUL_K};
            bmfs_pkg::D_MHI:
                phi_reg <= {{KW{1'b0}}, bytes_reg[TW-1:SPL]} * {{SPL{1'b0}}, bmfs_pkg::MUL_K};
            bmfs_pkg::D_PREP:
            begin
                rem_reg <= {{(TW-(NW-RW)){1'b0}}, num[NW-1:RW]};
                sh_reg  <= num[RW-1:0];
            end
            bmfs_pkg::D_RUN:
            begin
                rem_reg <= rem_next;
                sh_reg  <= sh_next;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/bmfs_back.sv */
// ----------------------------------------------------------------------------
// bmfs_back
// Takes classified items from the queue; for a sampled packet it computes the
// send and ack rates and updates the latest sample and the windowed max
// filter. The result of every item is registered.
// ----------------------------------------------------------------------------
module bmfs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bmfs_pkg::WIN_W-1:0]    cfg_data,
    input  logic                          empty,
    input  bmfs_pkg::entry_t              head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmfs_pkg::RATE_W-1:0]   best_rate,
    output logic [bmfs_pkg::RATE_W-1:0]   latest_rate,
    output logic                          is_app_limited,
    output logic                          estimate_updated
);

    localparam int RW = bmfs_pkg::RATE_W;
    localparam int TW = bmfs_pkg::ROUND_W;

    bmfs_pkg::back_state_t     state_reg, state_next;
    logic [bmfs_pkg::WIN_W-1:0] window_reg;
    logic [RW-1:0]             frate_reg [3];
    logic [TW-1:0]             fround_reg [3];
    logic [RW-1:0]             nrate [3];
    logic [TW-1:0]             nround [3];
    logic [RW-1:0]             latest_reg;
    logic                      app_reg, lim_reg, upd_reg;
    logic [TW-1:0]             round_reg;
    logic                      div_start, send_done, ack_done;
    logic [RW-1:0]             send_rate, ack_rate, meas;
    logic                      take_filter;
    logic                      out_load;
    logic                      out_valid_reg, lim_out_reg, upd_out_reg;
    logic [RW-1:0]             best_out_reg, latest_out_reg;
    logic [TW-1:0]             w, d0, d2, d0b, d1b, d2b;

    bmfs_div u_send (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .bytes (head.send_bytes),
        .us    (head.send_us),
        .done  (send_done),
        .rate  (send_rate)
    );

    bmfs_div u_ack (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .bytes (head.ack_bytes),
        .us    (head.ack_us),
        .done  (ack_done),
        .rate  (ack_rate)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmfs_pkg::B_IDLE:
                if (!empty) state_next = head.sample ? bmfs_pkg::B_WAIT : bmfs_pkg::B_DONE;
            bmfs_pkg::B_WAIT:
                if (send_done && ack_done) state_next = bmfs_pkg::B_UPD;
            bmfs_pkg::B_UPD:
                state_next = bmfs_pkg::B_DONE;
            bmfs_pkg::B_DONE:
                if (!out_valid_reg || out_ready) state_next = bmfs_pkg::B_IDLE;
            default:
                state_next = bmfs_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == bmfs_pkg::B_IDLE) && !empty;
        div_start = pop && head.sample;
        out_load  = (state_reg == bmfs_pkg::B_DONE) && (!out_valid_reg || out_ready);
    end

    assign meas        = (send_rate > ack_rate) ? send_rate : ack_rate;
    assign take_filter = (meas >= frate_reg[0]) || !app_reg;
    assign w           = {{(TW-bmfs_pkg::WIN_W){1'b0}}, window_reg};
    assign d0          = round_reg - fround_reg[0];
    assign d2          = round_reg - fround_reg[2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrate[k]  = frate_reg[k];
            nround[k] = fround_reg[k];
        end
        d0b = '0;
        d1b = '0;
        d2b = '0;
        if ((frate_reg[0] == '0) || (meas >= frate_reg[0]) || (d2 > w))
        begin
            for (int k = 0; k < 3; k++)
            begin
                nrate[k]  = meas;
                nround[k] = round_reg;
            end
        end
        else
        begin
            if (meas >= frate_reg[1])
            begin
                nrate[1] = meas;  nround[1] = round_reg;
                nrate[2] = meas;  nround[2] = round_reg;
            end
            else if (meas >= frate_reg[2])
            begin
                nrate[2] = meas;  nround[2] = round_reg;
            end
            d1b = round_reg - nround[1];
            d2b = round_reg - nround[2];
            if (d0 > w)
            begin
                nrate[0] = nrate[1];  nround[0] = nround[1];
                nrate[1] = nrate[2];  nround[1] = nround[2];
                nrate[2] = meas;      nround[2] = round_reg;
                d0b = round_reg - nround[0];
                if (d0b > w)
                begin
                    nrate[0] = nrate[1];  nround[0] = nround[1];
                    nrate[1] = nrate[2];  nround[1] = nround[2];
                end
            end
            else if ((nrate[1] == nrate[0]) && (d1b > (w >> 2)))
            begin
                nrate[1] = meas;  nround[1] = round_reg;
                nrate[2] = meas;  nround[2] = round_reg;
            end
            else if ((nrate[2] == nrate[1]) && (d2b > (w >> 1)))
            begin
                nrate[2] = meas;  nround[2] = round_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmfs_pkg::B_IDLE;
            window_reg    <= bmfs_pkg::WINDOW_RESET;
            latest_reg    <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                frate_reg[k]  <= '0;
                fround_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
            if (pop)
            begin
                upd_reg <= 1'b0;
            end
            if (state_reg == bmfs_pkg::B_UPD)
            begin
                if (!app_reg || (meas > latest_reg))
                begin
                    latest_reg <= meas;
                end
                if (take_filter)
                begin
                    upd_reg <= 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        frate_reg[k]  <= nrate[k];
                        fround_reg[k] <= nround[k];
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            app_reg   <= head.app;
            lim_reg   <= head.limited;
            round_reg <= head.round;
        end
        if (out_load)
        begin
            best_out_reg   <= frate_reg[0];
            latest_out_reg <= latest_reg;
            lim_out_reg    <= lim_reg;
            upd_out_reg    <= upd_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign best_rate        = best_out_reg;
    assign latest_rate      = latest_out_reg;
    assign is_app_limited   = lim_out_reg;
    assign estimate_updated = upd_out_reg;

endmodule

/* hw/rtl/bandwidth_max_filter_sampler.sv */
// ----------------------------------------------------------------------------
// bandwidth_max_filter_sampler
// Bandwidth sampler with a three-entry windowed max filter over rounds.
// ----------------------------------------------------------------------------
// A header, app-limited mark or skipped packet passes from the queue to the
// output register once it is free; an acked packet first waits for the
// two rate units (two partial products, a setup step, then 20 radix-4 steps).
// The back part takes one item at a time; a two-entry queue lets the input
// keep taking items meanwhile.
// Reset clears the filter, the latest sample and the event state at once.
module bandwidth_max_filter_sampler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bmfs_pkg::WIN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bmfs_pkg::CMD_W-1:0]    command,
    input  logic [bmfs_pkg::TIME_W-1:0]   now_time,
    input  logic [bmfs_pkg::TIME_W-1:0]   adjusted_time,
    input  logic [bmfs_pkg::TIME_W-1:0]   mark_time,
    input  logic [bmfs_pkg::TIME_W-1:0]   byte_total,
    input  logic [bmfs_pkg::TIME_W-1:0]   byte_count,
    input  logic [bmfs_pkg::TIME_W-1:0]   prior_ack_time,
    input  logic [bmfs_pkg::TIME_W-1:0]   prior_total_acked,
    input  logic [bmfs_pkg::ROUND_W-1:0]  round_count,
    input  logic                          has_prior,
    input  logic                          sent_app_limited,
    input  logic [bmfs_pkg::SIZE_W-1:0]   packet_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmfs_pkg::RATE_W-1:0]   best_rate,
    output logic [bmfs_pkg::RATE_W-1:0]   latest_rate,
    output logic                          is_app_limited,
    output logic                          estimate_updated
);

    bmfs_pkg::entry_t wr_entry, rd_entry;
    logic             push, pop, full, empty;

    assign in_ready = !full;
    assign push     = in_valid && in_ready;

    bmfs_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .command           (command),
        .now_time          (now_time),
        .adjusted_time     (adjusted_time),
        .mark_time         (mark_time),
        .byte_total        (byte_total),
        .byte_count        (byte_count),
        .prior_ack_time    (prior_ack_time),
        .prior_total_acked (prior_total_acked),
        .round_count       (round_count),
        .has_prior         (has_prior),
        .sent_app_limited  (sent_app_limited),
        .packet_size       (packet_size),
        .entry             (wr_entry)
    );

    bmfs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (empty)
    );

    bmfs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .empty            (empty),
        .head             (rd_entry),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .best_rate        (best_rate),
        .latest_rate      (latest_rate),
        .is_app_limited   (is_app_limited),
        .estimate_updated (estimate_updated)
    );

endmodule

/* hw/rtl/bmfs_checker.sv */
// ----------------------------------------------------------------------------
// bmfs_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bmfs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bmfs_pkg::RATE_W-1:0]   best_rate
);

    logic [2:0] pending_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result withdrawn before its transfer.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(best_rate))
        else $error("Stalled result changed.");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("Result shown with no item outstanding.");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("More items outstanding than the design can hold.");

endmodule

bind bandwidth_max_filter_sampler bmfs_checker u_bmfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .best_rate (best_rate)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bandwidth max filter sampler. Directed and random ack
// headers, acked packets and app-limited marks are sent through the input
// channel while the window register is changed between phases. A predictor
// in the testbench computes every expected result, and a checker compares
// each result transfer with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [63:0] RATE_LIMIT = (64'd1 << bmfs_pkg::RATE_W) - 1;
    localparam logic [63:0] TIME_MASK  = (64'd1 << bmfs_pkg::TIME_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [bmfs_pkg::CMD_W-1:0]   cmd;
        logic [bmfs_pkg::TIME_W-1:0]  now_t;
        logic [bmfs_pkg::TIME_W-1:0]  adj_t;
        logic [bmfs_pkg::TIME_W-1:0]  mark_t;
        logic [bmfs_pkg::TIME_W-1:0]  btot;
        logic [bmfs_pkg::TIME_W-1:0]  bcnt;
        logic [bmfs_pkg::TIME_W-1:0]  pack_t;
        logic [bmfs_pkg::TIME_W-1:0]  ptacked;
        logic [bmfs_pkg::ROUND_W-1:0] round;
        logic                         prior;
        logic                         app;
        logic [bmfs_pkg::SIZE_W-1:0]  size;
    } item_t;

    typedef struct packed {
        logic [bmfs_pkg::RATE_W-1:0] best;
        logic [bmfs_pkg::RATE_W-1:0] latest;
        logic                        limited;
        logic                        updated;
    } sample_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [bmfs_pkg::WIN_W-1:0] cfg_data;
    logic in_valid, in_ready;
    logic [bmfs_pkg::CMD_W-1:0] command;
    logic [bmfs_pkg::TIME_W-1:0] now_time, adjusted_time, mark_time, byte_total, byte_count;
    logic [bmfs_pkg::TIME_W-1:0] prior_ack_time, prior_total_acked;
    logic [bmfs_pkg::ROUND_W-1:0] round_count;
    logic has_prior, sent_app_limited;
    logic [bmfs_pkg::SIZE_W-1:0] packet_size;
    logic out_valid, out_ready;
    logic [bmfs_pkg::RATE_W-1:0] best_rate, latest_rate;
    logic is_app_limited, estimate_updated;

    bandwidth_max_filter_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .now_time(now_time), .adjusted_time(adjusted_time), .mark_time(mark_time),
        .byte_total(byte_total), .byte_count(byte_count),
        .prior_ack_time(prior_ack_time), .prior_total_acked(prior_total_acked),
        .round_count(round_count), .has_prior(has_prior),
        .sent_app_limited(sent_app_limited), .packet_size(packet_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .best_rate(best_rate), .latest_rate(latest_rate),
        .is_app_limited(is_app_limited), .estimate_updated(estimate_updated)
    );

    // Predictor state
    logic [bmfs_pkg::WIN_W-1:0]   win;
    logic [bmfs_pkg::RATE_W-1:0]  f_rate [3];
    logic [bmfs_pkg::ROUND_W-1:0] f_round [3];
    logic [bmfs_pkg::RATE_W-1:0]  last_sample;
    logic                         lim;
    logic [bmfs_pkg::TIME_W-1:0]  lim_exit, ev_ack, ev_adj, ev_tot, ev_bytes;
    logic [bmfs_pkg::ROUND_W-1:0] ev_round;

    sample_t expected_q[$];
    int errors, cycles, items_sent, results_seen, packets_sent, cfg_writes;
    logic quiet, pause_out;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [bmfs_pkg::RATE_W-1:0] bw_rate(logic [63:0] bytes,
                                                            logic [63:0] us);
        logic [127:0] prod;
        logic [127:0] q;
        if (us == 0)
            return '0;
        prod = {64'd0, bytes} * 128'd1000000;
        q = prod / {64'd0, us};
        return (q > {64'd0, RATE_LIMIT}) ? RATE_LIMIT[bmfs_pkg::RATE_W-1:0]
                                         : q[bmfs_pkg::RATE_W-1:0];
    endfunction

    function automatic void put_entry(int k, logic [bmfs_pkg::RATE_W-1:0] v,
                                      logic [bmfs_pkg::ROUND_W-1:0] t);
        f_rate[k] = v;
        f_round[k] = t;
    endfunction

    function automatic void max_filter_insert(logic [bmfs_pkg::RATE_W-1:0] v,
                                              logic [bmfs_pkg::ROUND_W-1:0] t);
        logic [bmfs_pkg::ROUND_W-1:0] w;
        logic [bmfs_pkg::ROUND_W-1:0] d;
        w = {24'd0, win};
        d = t - f_round[2];
        if (f_rate[0] == 0 || v >= f_rate[0] || d > w) begin
            for (int k = 0; k < 3; k++) put_entry(k, v, t);
            return;
        end
        if (v >= f_rate[1]) begin
            put_entry(1, v, t);
            put_entry(2, v, t);
        end else if (v >= f_rate[2]) begin
            put_entry(2, v, t);
        end
        d = t - f_round[0];
        if (d > w) begin
            put_entry(0, f_rate[1], f_round[1]);
            put_entry(1, f_rate[2], f_round[2]);
            put_entry(2, v, t);
            d = t - f_round[0];
            if (d > w) begin
                put_entry(0, f_rate[1], f_round[1]);
                put_entry(1, f_rate[2], f_round[2]);
            end
            return;
        end
        d = t - f_round[1];
        if (f_rate[1] == f_rate[0] && d > (w >> 2)) begin
            put_entry(1, v, t);
            put_entry(2, v, t);
            return;
        end
        d = t - f_round[2];
        if (f_rate[2] == f_rate[1] && d > (w >> 1))
            put_entry(2, v, t);
    endfunction

    function automatic sample_t predict_sample(item_t it);
        sample_t s;
        logic [bmfs_pkg::RATE_W-1:0] send_r, ack_r, meas;
        logic [bmfs_pkg::TIME_W-1:0] db, dt, da, dur;
        logic upd;
        upd = 1'b0;
        if (it.cmd == bmfs_pkg::CMD_HEADER) begin
            ev_ack = it.now_t;
            ev_adj = it.adj_t;
            ev_tot = it.btot;
            ev_bytes = it.bcnt;
            ev_round = it.round;
            if (lim && lim_exit < it.mark_t)
                lim = 1'b0;
        end else if (it.cmd == bmfs_pkg::CMD_PACKET && it.size != 0) begin
            send_r = '0;
            ack_r = '0;
            if (it.prior) begin
                db = it.btot > it.bcnt ? it.btot - it.bcnt : '0;
                dt = it.now_t > it.mark_t ? it.now_t - it.mark_t : '0;
                send_r = bw_rate(64'(db), 64'(dt));
                da = ev_tot > it.ptacked ? ev_tot - it.ptacked : '0;
                if (ev_adj > it.adj_t)
                    dur = ev_adj - it.adj_t;
                else
                    dur = ev_ack > it.pack_t ? ev_ack - it.pack_t : '0;
                ack_r = bw_rate(64'(da), 64'(dur));
            end else if (ev_ack > it.now_t) begin
                dt = ev_ack - it.now_t;
                send_r = bw_rate(64'(ev_bytes), 64'(dt));
            end
            meas = send_r > ack_r ? send_r : ack_r;
            if (!it.app || meas > last_sample)
                last_sample = meas;
            if (meas >= f_rate[0] || !it.app) begin
                max_filter_insert(meas, ev_round);
                upd = 1'b1;
            end
        end else if (it.cmd == bmfs_pkg::CMD_APP_LIMITED) begin
            lim = 1'b1;
            lim_exit = it.now_t;
        end
        s.best = f_rate[0];
        s.latest = last_sample;
        s.limited = lim;
        s.updated = upd;
        return s;
    endfunction

    function automatic logic [bmfs_pkg::TIME_W-1:0] rand_wide();
        logic [bmfs_pkg::TIME_W-1:0] v;
        v = bmfs_pkg::TIME_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: return '0;
            1: return TIME_MASK[bmfs_pkg::TIME_W-1:0];
            2: return v >> $urandom_range(0, bmfs_pkg::TIME_W - 1);
            default: return v;
        endcase
    endfunction

    // Result checker with random backpressure
    always @(posedge clk or negedge rst_n) begin
        sample_t exp_s;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result best=%0d latest=%0d", $time,
                             best_rate, latest_rate);
                    errors <= errors + 1;
                end else begin
                    exp_s = expected_q.pop_front();
                    if (best_rate !== exp_s.best || latest_rate !== exp_s.latest ||
                        is_app_limited !== exp_s.limited ||
                        estimate_updated !== exp_s.updated) begin
                        $display("%0t: mismatch expected best=%0d latest=%0d lim=%0d upd=%0d",
                                 $time, exp_s.best, exp_s.latest, exp_s.limited,
                                 exp_s.updated);
                        $display("%0t:           actual best=%0d latest=%0d lim=%0d upd=%0d",
                                 $time, best_rate, latest_rate, is_app_limited,
                                 estimate_updated);
                        errors <= errors + 1;
                    end
                end
            end
            out_ready <= quiet ? 1'b1 : !pause_out && ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic send_item(item_t it);
        int gap;
        gap = quiet ? 0 : ($urandom_range(0, 99) < 24 ? $urandom_range(1, 4) : 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {command, now_time, adjusted_time, mark_time, byte_total, byte_count,
         prior_ack_time, prior_total_acked, round_count, has_prior,
         sent_app_limited, packet_size} <= it;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(predict_sample(it));
        items_sent++;
        if (it.cmd == bmfs_pkg::CMD_PACKET) packets_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_window(logic [bmfs_pkg::WIN_W-1:0] w);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win = w;
        cfg_writes++;
    endtask

    function automatic item_t random_item(int cmd_sel);
        item_t it;
        it = '0;
        it.cmd = bmfs_pkg::CMD_W'(cmd_sel);
        it.now_t = rand_wide();
        it.adj_t = rand_wide();
        it.mark_t = rand_wide();
        it.btot = rand_wide();
        it.bcnt = rand_wide();
        it.pack_t = rand_wide();
        it.ptacked = rand_wide();
        it.round = {$urandom};
        it.prior = 1'($urandom_range(0, 1));
        it.app = 1'($urandom_range(0, 1));
        it.size = $urandom_range(0, 9) == 0 ? '0 : bmfs_pkg::SIZE_W'($urandom);
        return it;
    endfunction

    // A realistic ack flow with plausible times and byte counts
    logic [bmfs_pkg::TIME_W-1:0] flow_time, flow_acked;
    logic [bmfs_pkg::ROUND_W-1:0] flow_round;

    task automatic send_flow_event();
        item_t hdr, pkt;
        int n;
        hdr = '0;
        flow_time += bmfs_pkg::TIME_W'($urandom_range(1, 5000));
        flow_acked += bmfs_pkg::TIME_W'($urandom_range(0, 200000));
        if ($urandom_range(0, 3) == 0) flow_round += $urandom_range(1, 12);
        hdr.cmd = bmfs_pkg::CMD_HEADER;
        hdr.now_t = flow_time;
        hdr.adj_t = flow_time - bmfs_pkg::TIME_W'($urandom_range(0, 200));
        hdr.mark_t = flow_time - bmfs_pkg::TIME_W'($urandom_range(0, 20000));
        hdr.btot = flow_acked;
        hdr.bcnt = bmfs_pkg::TIME_W'($urandom_range(0, 100000));
        hdr.round = flow_round;
        send_item(hdr);
        n = $urandom_range(1, 3);
        repeat (n) begin
            pkt = '0;
            pkt.cmd = bmfs_pkg::CMD_PACKET;
            pkt.now_t = flow_time - bmfs_pkg::TIME_W'($urandom_range(0, 40000));
            pkt.adj_t = flow_time - bmfs_pkg::TIME_W'($urandom_range(0, 60000));
            pkt.mark_t = pkt.now_t - bmfs_pkg::TIME_W'($urandom_range(0, 30000));
            pkt.btot = flow_acked + bmfs_pkg::TIME_W'($urandom_range(0, 300000));
            pkt.bcnt = pkt.btot - bmfs_pkg::TIME_W'($urandom_range(0, 400000));
            pkt.pack_t = flow_time - bmfs_pkg::TIME_W'($urandom_range(0, 60000));
            pkt.ptacked = flow_acked - bmfs_pkg::TIME_W'($urandom_range(0, 400000));
            pkt.prior = $urandom_range(0, 4) != 0;
            pkt.app = $urandom_range(0, 3) == 0;
            pkt.size = bmfs_pkg::SIZE_W'($urandom_range(1, 1500));
            send_item(pkt);
        end
        if ($urandom_range(0, 9) == 0) begin
            pkt = '0;
            pkt.cmd = bmfs_pkg::CMD_APP_LIMITED;
            pkt.now_t = flow_time;
            send_item(pkt);
        end
    endtask

    task automatic test_directed();
        item_t it;
        it = '0;
        it.cmd = bmfs_pkg::CMD_HEADER;
        it.now_t = 48'd1000; it.adj_t = 48'd900; it.btot = 48'd50000;
        it.bcnt = 48'd3000; it.round = 32'd5;
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_PACKET; it.size = 16'd1200;
        it.now_t = 48'd400;
        send_item(it);
        it.prior = 1'b1; it.now_t = 48'd500; it.mark_t = 48'd400;
        it.btot = 48'd20000; it.bcnt = 48'd10000; it.adj_t = 48'd100;
        it.ptacked = 48'd1000;
        send_item(it);
        it.now_t = 48'd400; it.btot = 48'd5; it.bcnt = 48'd9;
        it.adj_t = 48'd950; it.pack_t = 48'd10;
        send_item(it);
        it.pack_t = 48'd2000;
        send_item(it);
        it.size = '0;
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_PACKET; it.size = 16'hFFFF; it.prior = 1'b1;
        it.now_t = TIME_MASK[bmfs_pkg::TIME_W-1:0]; it.mark_t = 48'd0;
        it.btot = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        it.adj_t = 48'd899; it.ptacked = 48'd0;
        send_item(it);
        it.now_t = 48'd1; it.btot = TIME_MASK[bmfs_pkg::TIME_W-1:0]; it.bcnt = 48'd0;
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_APP_LIMITED; it.now_t = 48'd7000;
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_PACKET; it.size = 16'd1; it.app = 1'b1; it.now_t = 48'd999;
        send_item(it);
        it.now_t = 48'd0;
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_HEADER; it.mark_t = 48'd7000; it.round = 32'hFFFF_FFFF;
        send_item(it);
        it.mark_t = 48'd7001; it.now_t = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        it.bcnt = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        it.adj_t = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        it.btot = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        send_item(it);
        it = '0;
        it.cmd = bmfs_pkg::CMD_PACKET; it.size = 16'd100; it.now_t = 48'd0;
        send_item(it);
        it = '0;
        it.cmd = CMD_UNUSED; it.now_t = TIME_MASK[bmfs_pkg::TIME_W-1:0];
        it.size = 16'hFFFF;
        send_item(it);
    endtask

    task automatic test_random_noise(int count);
        repeat (count) send_item(random_item($urandom_range(0, 3)));
    endtask

    task automatic test_flow(int events);
        repeat (events) send_flow_event();
    endtask

    initial begin
        errors = 0; cycles = 0; items_sent = 0; results_seen = 0;
        packets_sent = 0; cfg_writes = 0;
        quiet = 1'b0; pause_out = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        in_valid = 1'b0; command = '0;
        now_time = '0; adjusted_time = '0; mark_time = '0; byte_total = '0;
        byte_count = '0; prior_ack_time = '0; prior_total_acked = '0;
        round_count = '0; has_prior = 1'b0; sent_app_limited = 1'b0;
        packet_size = '0;
        win = bmfs_pkg::WINDOW_RESET;
        for (int k = 0; k < 3; k++) put_entry(k, '0, '0);
        last_sample = '0; lim = 1'b0; lim_exit = '0;
        ev_ack = '0; ev_adj = '0; ev_tot = '0; ev_bytes = '0; ev_round = '0;
        flow_time = 48'd100000; flow_acked = 48'd1000000; flow_round = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_window(8'd1);
        test_flow(100);
        test_random_noise(80);
        write_window(8'd255);
        quiet = 1'b1;
        test_flow(120);
        quiet = 1'b0;
        drain();
        write_window(8'd0);
        test_flow(60);
        write_window(bmfs_pkg::WIN_W'($urandom_range(2, 30)));
        test_flow(120);
        test_random_noise(80);
        in_valid <= 1'b0;
        pause_out = 1'b1;
        repeat (60) @(posedge clk);
        pause_out = 1'b0;
        write_window(bmfs_pkg::WIN_W'($urandom_range(1, 255)));
        test_flow(100);
        test_random_noise(60);

        drain();
        $display("Sent %0d items (%0d packets) with %0d window writes; %0d results checked.",
                 items_sent, packets_sent, cfg_writes, results_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
